// File: rtl/assert_macros.svh
// Assertion macros for the RTL, included by the controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("assertion failed");

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/sbsh_pkg.sv
// Shared types, constants and tables of the SHA-256 byte stream hasher.
package sbsh_pkg;

    localparam logic [5:0] ROUND_LAST     = 6'd63;
    localparam logic [5:0] FILL_LAST      = 6'd63;
    localparam logic [5:0] FILL_LEN_START = 6'd56;
    localparam logic [2:0] WORD_LAST      = 3'd7;
    localparam logic [7:0] PAD_BYTE       = 8'h80;
    localparam logic       CMD_ABSORB     = 1'b0;
    localparam logic       CMD_FINALIZE   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_UPDATE,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        BK_DATA,
        BK_PAD80,
        BK_ZERO,
        BK_LEN
    } t_byte_kind;

    typedef struct packed {
        logic       load_byte;
        t_byte_kind byte_kind;
        logic       latch_len;
        logic       init_work;
        logic       do_round;
        logic [5:0] round_idx;
        logic       add_hash;
        logic [2:0] emit_idx;
        logic       reset_msg;
    } t_dp_cmd;

    typedef struct packed {
        logic [5:0] fill;
    } t_dp_status;

    function automatic logic [31:0] ror32(logic [31:0] v, int unsigned n);
        return (v >> n) | (v << (32 - n));
    endfunction

    function automatic logic [31:0] init_hash(logic [2:0] idx);
        logic [31:0] h;
        case (idx)
            3'd0: h = 32'h6a09e667;
            3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372;
            3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f;
            3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab;
            default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

    function automatic logic [31:0] round_k(logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

endpackage

// File: rtl/sbsh_datapath.sv
// Datapath: block word packing, schedule window, round logic, hash words.
module sbsh_datapath
    import sbsh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_data_byte,
    input  t_dp_cmd     i_cmd,
    output t_dp_status  o_status,
    output logic [31:0] o_digest_word
);

    logic [23:0] r_acc;
    logic [31:0] r_win [16];
    logic [31:0] r_wv  [8];
    logic [31:0] r_hash[8];
    logic [5:0]  r_fill;
    logic [63:0] r_bit_len;
    logic [63:0] r_len;

    logic [7:0]  byte_val;
    logic [31:0] sched_new;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] big_s0;
    logic [31:0] big_s1;
    logic [31:0] sm_s0;
    logic [31:0] sm_s1;
    logic [31:0] ch;
    logic [31:0] maj;

    always_comb begin
        case (i_cmd.byte_kind)
            BK_DATA:  byte_val = i_data_byte;
            BK_PAD80: byte_val = PAD_BYTE;
            BK_LEN:   byte_val = r_len[63:56];
            default:  byte_val = 8'h00;
        endcase
    end

    // window holds w[t]..w[t+15], oldest at index 0
    always_comb begin
        sm_s0     = ror32(r_win[1], 7) ^ ror32(r_win[1], 18) ^ (r_win[1] >> 3);
        sm_s1     = ror32(r_win[14], 17) ^ ror32(r_win[14], 19) ^ (r_win[14] >> 10);
        sched_new = sm_s1 + r_win[9] + sm_s0 + r_win[0];
        big_s1    = ror32(r_wv[4], 6) ^ ror32(r_wv[4], 11) ^ ror32(r_wv[4], 25);
        big_s0    = ror32(r_wv[0], 2) ^ ror32(r_wv[0], 13) ^ ror32(r_wv[0], 22);
        ch        = (r_wv[4] & r_wv[5]) ^ (~r_wv[4] & r_wv[6]);
        maj       = (r_wv[0] & r_wv[1]) ^ (r_wv[0] & r_wv[2]) ^ (r_wv[1] & r_wv[2]);
        t1        = r_wv[7] + big_s1 + ch + round_k(i_cmd.round_idx) + r_win[0];
        t2        = big_s0 + maj;
    end

    // byte packing, schedule window and length shift register, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_byte) begin
            r_acc <= {r_acc[15:0], byte_val};
            if (r_fill[1:0] == 2'd3) begin
                for (int i = 0; i < 15; i++) begin
                    r_win[i] <= r_win[i + 1];
                end
                r_win[15] <= {r_acc, byte_val};
            end
        end else if (i_cmd.do_round) begin
            for (int i = 0; i < 15; i++) begin
                r_win[i] <= r_win[i + 1];
            end
            r_win[15] <= sched_new;
        end
        if (i_cmd.latch_len) begin
            r_len <= r_bit_len;
        end else if (i_cmd.load_byte && (i_cmd.byte_kind == BK_LEN)) begin
            r_len <= {r_len[55:0], 8'h00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_bit_len <= '0;
            for (int i = 0; i < 8; i++) begin
                r_hash[i] <= init_hash(3'(i));
                r_wv[i]   <= '0;
            end
        end else begin
            if (i_cmd.load_byte) begin
                r_fill <= r_fill + 6'd1;
                if (i_cmd.byte_kind == BK_DATA) begin
                    r_bit_len <= r_bit_len + 64'd8;
                end
            end
            if (i_cmd.init_work) begin
                for (int i = 0; i < 8; i++) begin
                    r_wv[i] <= r_hash[i];
                end
            end else if (i_cmd.do_round) begin
                r_wv[7] <= r_wv[6];
                r_wv[6] <= r_wv[5];
                r_wv[5] <= r_wv[4];
                r_wv[4] <= r_wv[3] + t1;
                r_wv[3] <= r_wv[2];
                r_wv[2] <= r_wv[1];
                r_wv[1] <= r_wv[0];
                r_wv[0] <= t1 + t2;
            end
            if (i_cmd.add_hash) begin
                for (int i = 0; i < 8; i++) begin
                    r_hash[i] <= r_hash[i] + r_wv[i];
                end
            end else if (i_cmd.reset_msg) begin
                r_bit_len <= '0;
                r_fill    <= '0;
                for (int i = 0; i < 8; i++) begin
                    r_hash[i] <= init_hash(3'(i));
                end
            end
        end
    end

    assign o_status.fill = r_fill;
    assign o_digest_word = r_hash[i_cmd.emit_idx];

endmodule

// File: rtl/sbsh_ctrl.sv
// Controller: sequences byte loads, padding, rounds, hash update and digest output.
`include "assert_macros.svh"

module sbsh_ctrl
    import sbsh_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic       i_s_cmd,
    input  logic       i_m_tready,
    input  t_dp_status i_status,
    output logic       o_s_tready,
    output logic       o_m_tvalid,
    output logic       o_m_tlast,
    output t_dp_cmd    o_cmd
);

    t_state     r_state, n_state;
    logic [5:0] r_round, n_round;
    logic [2:0] r_emit_idx, n_emit_idx;
    logic       r_pad, n_pad;
    logic       r_first, n_first;
    logic       r_len_ok, n_len_ok;
    logic       r_final, n_final;

    logic       s_accept;
    logic       m_accept;
    logic       fill_full;
    t_byte_kind pad_kind;

    assign s_accept  = i_s_tvalid && o_s_tready;
    assign m_accept  = o_m_tvalid && i_m_tready;
    assign fill_full = (i_status.fill == FILL_LAST);

    // length bytes only go in once the 0x80 marker sits in a block with room for them
    always_comb begin
        if (r_first) begin
            pad_kind = BK_PAD80;
        end else if (r_len_ok && (i_status.fill >= FILL_LEN_START)) begin
            pad_kind = BK_LEN;
        end else begin
            pad_kind = BK_ZERO;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    if (i_s_cmd == CMD_FINALIZE) begin
                        n_state = ST_PAD;
                    end else if (fill_full) begin
                        n_state = ST_ROUND;
                    end
                end
            end
            ST_PAD: begin
                if (fill_full) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (r_round == ROUND_LAST) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (r_final) begin
                    n_state = ST_EMIT;
                end else if (r_pad) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (m_accept && (r_emit_idx == WORD_LAST)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.round_idx = r_round;
        o_cmd.emit_idx  = r_emit_idx;
        o_s_tready      = 1'b0;
        o_m_tvalid      = 1'b0;
        o_m_tlast       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (s_accept) begin
                    if (i_s_cmd == CMD_FINALIZE) begin
                        o_cmd.latch_len = 1'b1;
                    end else begin
                        o_cmd.load_byte = 1'b1;
                        o_cmd.byte_kind = BK_DATA;
                        o_cmd.init_work = fill_full;
                    end
                end
            end
            ST_PAD: begin
                o_cmd.load_byte = 1'b1;
                o_cmd.byte_kind = pad_kind;
                o_cmd.init_work = fill_full;
            end
            ST_ROUND: begin
                o_cmd.do_round = 1'b1;
            end
            ST_UPDATE: begin
                o_cmd.add_hash = 1'b1;
            end
            ST_EMIT: begin
                o_m_tvalid      = 1'b1;
                o_m_tlast       = (r_emit_idx == WORD_LAST);
                o_cmd.reset_msg = m_accept && (r_emit_idx == WORD_LAST);
            end
            default: ;
        endcase
    end

    always_comb begin
        n_round    = r_round;
        n_emit_idx = r_emit_idx;
        n_pad      = r_pad;
        n_first    = r_first;
        n_len_ok   = r_len_ok;
        n_final    = r_final;
        case (r_state)
            ST_IDLE: begin
                if (s_accept && (i_s_cmd == CMD_FINALIZE)) begin
                    n_pad    = 1'b1;
                    n_first  = 1'b1;
                    n_len_ok = 1'b0;
                    n_final  = 1'b0;
                end
            end
            ST_PAD: begin
                n_first = 1'b0;
                if (r_first && (i_status.fill < FILL_LEN_START)) begin
                    n_len_ok = 1'b1;
                end
                if ((pad_kind == BK_LEN) && fill_full) begin
                    n_final = 1'b1;
                end
            end
            ST_ROUND: begin
                n_round = r_round + 6'd1;
            end
            ST_UPDATE: begin
                if (r_pad) begin
                    n_len_ok = 1'b1;
                end
            end
            ST_EMIT: begin
                if (m_accept) begin
                    n_emit_idx = r_emit_idx + 3'd1;
                    if (r_emit_idx == WORD_LAST) begin
                        n_pad   = 1'b0;
                        n_final = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_round    <= '0;
            r_emit_idx <= '0;
            r_pad      <= 1'b0;
            r_first    <= 1'b0;
            r_len_ok   <= 1'b0;
            r_final    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_round    <= n_round;
            r_emit_idx <= n_emit_idx;
            r_pad      <= n_pad;
            r_first    <= n_first;
            r_len_ok   <= n_len_ok;
            r_final    <= n_final;
        end
    end

    `ASSERT_ALWAYS(a_no_in_during_out, i_clk, i_rst_n, !(o_s_tready && o_m_tvalid))
    `ASSERT_IMPL(a_update_after_last_round, i_clk, i_rst_n, r_state == ST_UPDATE,
                 $past(r_state) == ST_ROUND && $past(r_round) == ROUND_LAST)
    `ASSERT_IMPL(a_emit_block_empty, i_clk, i_rst_n, o_m_tvalid, i_status.fill == '0)
    `ASSERT_NEXT(a_ready_after_digest, i_clk, i_rst_n, m_accept && o_m_tlast,
                 o_s_tready && !r_pad)

endmodule

// File: rtl/sha256_byte_stream_hasher_core.sv
// Top level of the SHA-256 byte stream hasher.
// SHA-256 over a byte stream. Each input word carries one message byte (tuser low) or a
// finalize request (tuser high). Bytes are taken one per cycle; the 64th byte of a block
// starts the compression, which runs one round per cycle through a single round unit,
// followed by the hash update, and input stalls through the rounds and the update of each
// block. Finalize pads serially through the same byte path, one pad byte per cycle up to
// the block end, then one or two compressions, and then presents the eight digest words,
// most significant first, with tlast on the eighth; no input is taken until the last word
// is accepted. After that the initial hash is reloaded and the length counter cleared for
// the next message.
module sha256_byte_stream_hasher_core
    import sbsh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic [0:0]  i_s_tuser,   // [0] cmd
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] digest_word
    output logic [2:0]  o_m_tuser,   // [2:0] word_index
    output logic        o_m_tlast
);

    t_dp_cmd    cmd;
    t_dp_status status;

    sbsh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_cmd    (i_s_tuser[0]),
        .i_m_tready (i_m_tready),
        .i_status   (status),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tlast  (o_m_tlast),
        .o_cmd      (cmd)
    );

    sbsh_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_data_byte   (i_s_tdata),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_digest_word (o_m_tdata)
    );

    assign o_m_tuser = cmd.emit_idx;

endmodule
